[rtl/core/pps_pkg.sv]
`default_nettype none
package pps_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;
  localparam int PRIO_BITS_DEF = 8;

  // fixed widths of the slot fields on the ports
  localparam int SLOT_FIELD_W = 4;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic upd;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[rtl/core/preemptive_priority_scheduler.sv]
// tick item: result set by the slot scan that reads the task table one entry
// per cycle, then registered through the drain, update and finish states; next
// item taken once the result is registered, later while the previous result is held
// load item: no result; next item taken while a result waits
// reset (rst_n low, synchronous): time zero, all slots empty, no result
// table contents are not cleared; empty slots are never selected
`default_nettype none
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  localparam int IN_W  = ((SLOT_FIELD_W + 2 * TIME_BITS + PRIO_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SLOT_FIELD_W + 2 * TIME_BITS + 3 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // slot, arrival_time, burst_length, prio_level
  input  wire logic [IN_W-1:0]  in_tdata,
  // kind
  input  wire logic             in_tuser,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // idle, running_slot, finished, turnaround_time, waiting_time, all_done
  output logic [OUT_W-1:0]      out_tdata
);

  cmd_t    cmd;
  status_t status;

  logic                    o_idle, o_fin, o_all_done;
  logic [SLOT_FIELD_W-1:0] o_slot;
  logic [TIME_BITS-1:0]    o_tat, o_wt;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (kind_t'(in_tuser)),
    .status    (status),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  pps_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_slot             (in_tdata[SLOT_FIELD_W-1:0]),
    .in_arrival_time     (in_tdata[SLOT_FIELD_W +: TIME_BITS]),
    .in_burst_length     (in_tdata[SLOT_FIELD_W + TIME_BITS +: TIME_BITS]),
    .in_prio_level       (in_tdata[SLOT_FIELD_W + 2 * TIME_BITS +: PRIO_BITS]),
    .out_tready          (out_tready),
    .out_valid           (out_tvalid),
    .out_idle            (o_idle),
    .out_running_slot    (o_slot),
    .out_finished        (o_fin),
    .out_turnaround_time (o_tat),
    .out_waiting_time    (o_wt),
    .out_all_done        (o_all_done)
  );

  assign out_tdata = OUT_W'({o_all_done, o_wt, o_tat, o_fin, o_slot, o_idle});

endmodule
`default_nettype wire

[rtl/core/pps_ctrl.sv]
`default_nettype none
module pps_ctrl
  import pps_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  input  wire kind_t   in_kind,
  input  wire status_t status,
  output logic         in_tready,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (in_kind == KIND_TICK)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_FIN;
      ST_FIN: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid && (in_kind == KIND_LOAD);
        cmd.start = in_tvalid && (in_kind == KIND_TICK);
      end
      ST_SCAN:  cmd.step = 1'b1;
      ST_DRAIN: cmd      = '0;
      ST_UPD:   cmd.upd  = 1'b1;
      ST_FIN:   cmd.fin  = status.out_free;
      default:  cmd      = '0;
    endcase
  end

  a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> $past(state_r == ST_SCAN))
    else $error("drain entered without a scan");

endmodule
`default_nettype wire

[rtl/core/pps_dp.sv]
`default_nettype none
module pps_dp
  import pps_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cmd_t                    cmd,
  output status_t                      status,
  input  wire logic [SLOT_FIELD_W-1:0] in_slot,
  input  wire logic [TIME_BITS-1:0]    in_arrival_time,
  input  wire logic [TIME_BITS-1:0]    in_burst_length,
  input  wire logic [PRIO_BITS-1:0]    in_prio_level,
  input  wire logic                    out_tready,
  output logic                         out_valid,
  output logic                         out_idle,
  output logic [SLOT_FIELD_W-1:0]      out_running_slot,
  output logic                         out_finished,
  output logic [TIME_BITS-1:0]         out_turnaround_time,
  output logic [TIME_BITS-1:0]         out_waiting_time,
  output logic                         out_all_done
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int IDX_W  = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

  // task table
  logic [TIME_BITS-1:0] mem_arr [NUM_SLOTS];
  logic [TIME_BITS-1:0] mem_bst [NUM_SLOTS];
  logic [TIME_BITS-1:0] mem_rem [NUM_SLOTS];
  logic [PRIO_BITS-1:0] mem_pri [NUM_SLOTS];

  logic [TIME_BITS-1:0] rd_arr_r, rd_bst_r, rd_rem_r;
  logic [PRIO_BITS-1:0] rd_pri_r;

  logic [NUM_SLOTS-1:0] valid_r, done_r;
  logic [CNT_W-1:0]     pend_r;
  logic [TIME_BITS-1:0] time_r;

  logic [SLOT_W-1:0]    scan_idx_r, cmp_idx_r;
  logic                 cmp_en_r;

  logic                 found_r;
  logic [SLOT_W-1:0]    best_idx_r;
  logic [PRIO_BITS-1:0] best_pri_r;
  logic [TIME_BITS-1:0] best_arr_r, best_bst_r, best_rem_r;

  logic                 fin_r;
  logic [TIME_BITS-1:0] tat_r;

  logic                 out_valid_r, out_idle_r, out_fin_r, out_all_done_r;
  logic [SLOT_FIELD_W-1:0] out_slot_r;
  logic [TIME_BITS-1:0] out_tat_r, out_wt_r;

  logic [SLOT_W-1:0]    ld_idx;
  logic                 ld_ok;
  logic                 ld_we;
  logic [SLOT_W-1:0]    wr_addr;
  logic                 rem_we;
  logic [TIME_BITS-1:0] rem_wdata;
  logic [TIME_BITS-1:0] new_rem;
  logic [TIME_BITS:0]   tat_full;
  logic [TIME_BITS-1:0] tat_sat;
  logic [TIME_BITS-1:0] wt;
  logic                 elig, better;
  logic [IDX_W-1:0]     best_wide;

  assign ld_idx  = SLOT_W'(IDX_W'(in_slot));
  assign ld_ok   = (IDX_W + 1)'(in_slot) < (IDX_W + 1)'(NUM_SLOTS);
  assign ld_we   = cmd.load && ld_ok;
  assign wr_addr = cmd.load ? ld_idx : best_idx_r;

  assign new_rem   = (best_rem_r == '0) ? '0 : best_rem_r - TIME_BITS'(1);
  assign rem_we    = ld_we || (cmd.upd && found_r);
  assign rem_wdata = cmd.load ? in_burst_length : new_rem;

  // task is known to have arrived, so no underflow here
  assign tat_full = {1'b0, time_r} + (TIME_BITS + 1)'(1) - {1'b0, best_arr_r};
  assign tat_sat  = tat_full[TIME_BITS] ? '1 : tat_full[TIME_BITS-1:0];
  assign wt       = (tat_r >= best_bst_r) ? tat_r - best_bst_r : '0;

  assign elig   = valid_r[cmp_idx_r] && !done_r[cmp_idx_r] && (rd_arr_r <= time_r);
  assign better = !found_r || (rd_pri_r < best_pri_r);

  assign best_wide = IDX_W'(best_idx_r);

  always_ff @(posedge clk) begin
    if (ld_we) begin
      mem_arr[wr_addr] <= in_arrival_time;
      mem_bst[wr_addr] <= in_burst_length;
      mem_pri[wr_addr] <= in_prio_level;
    end
    if (rem_we) begin
      mem_rem[wr_addr] <= rem_wdata;
    end
    rd_arr_r <= mem_arr[scan_idx_r];
    rd_bst_r <= mem_bst[scan_idx_r];
    rd_rem_r <= mem_rem[scan_idx_r];
    rd_pri_r <= mem_pri[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      done_r      <= '0;
      pend_r      <= '0;
      time_r      <= '0;
      scan_idx_r  <= '0;
      cmp_idx_r   <= '0;
      cmp_en_r    <= 1'b0;
      found_r     <= 1'b0;
      best_idx_r  <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.step;
      if (cmd.step) begin
        cmp_idx_r  <= scan_idx_r;
        scan_idx_r <= scan_idx_r + SLOT_W'(1);
      end
      if (ld_we) begin
        valid_r[ld_idx] <= 1'b1;
        done_r[ld_idx]  <= 1'b0;
        if (!(valid_r[ld_idx] && !done_r[ld_idx])) pend_r <= pend_r + CNT_W'(1);
      end
      if (cmd.start) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
        best_idx_r <= '0;
      end
      if (cmp_en_r && elig && better) begin
        found_r    <= 1'b1;
        best_idx_r <= cmp_idx_r;
      end
      if (cmd.upd) begin
        fin_r <= found_r && (new_rem == '0);
        if (found_r && (new_rem == '0)) begin
          done_r[best_idx_r] <= 1'b1;
          pend_r             <= pend_r - CNT_W'(1);
        end
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
        if (time_r != '1) time_r <= time_r + TIME_BITS'(1);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en_r && elig && better) begin
      best_pri_r <= rd_pri_r;
      best_arr_r <= rd_arr_r;
      best_bst_r <= rd_bst_r;
      best_rem_r <= rd_rem_r;
    end
    if (cmd.upd) begin
      tat_r <= tat_sat;
    end
    if (cmd.fin) begin
      out_idle_r     <= !found_r;
      out_slot_r     <= found_r ? best_wide[SLOT_FIELD_W-1:0] : '0;
      out_fin_r      <= fin_r;
      out_tat_r      <= fin_r ? tat_r : '0;
      out_wt_r       <= fin_r ? wt : '0;
      out_all_done_r <= (pend_r == '0);
    end
  end

  assign status.scan_last = (scan_idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign status.out_free  = !out_valid_r || out_tready;

  assign out_valid           = out_valid_r;
  assign out_idle            = out_idle_r;
  assign out_running_slot    = out_slot_r;
  assign out_finished        = out_fin_r;
  assign out_turnaround_time = out_tat_r;
  assign out_waiting_time    = out_wt_r;
  assign out_all_done        = out_all_done_r;

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= CNT_W'(NUM_SLOTS))
    else $error("pending count beyond table size");

  a_fin_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fin_r) |-> (!out_idle_r && (out_wt_r <= out_tat_r)))
    else $error("finished item idle or waiting above turnaround");

  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (time_r >= $past(time_r)))
    else $error("time counter went backwards");

endmodule
`default_nettype wire

[verif/testbench.sv]
`default_nettype none
module testbench;
  import pps_pkg::*;

  localparam int IN_W = ((SLOT_FIELD_W + 2 * TIME_BITS_DEF + PRIO_BITS_DEF + 7) / 8) * 8;
  localparam int OUT_W = ((SLOT_FIELD_W + 2 * TIME_BITS_DEF + 3 + 7) / 8) * 8;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AFTER = 200;
  localparam int RANDOM_ITEMS = 1900;
  localparam logic [15:0] TIME_MAX = 16'hFFFF;

  typedef struct {
    kind_t       kind;
    logic [3:0]  slot;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    int          gap;
    bit          wait_drain;
  } sched_item_t;

  // idle sits in the lowest bit
  typedef struct packed {
    logic        all_done;
    logic [15:0] waiting;
    logic [15:0] turnaround;
    logic        finished;
    logic [3:0]  slot;
    logic        idle;
  } sched_result_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  preemptive_priority_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  sched_item_t   pending_items[$];
  sched_result_t sched_expect[$];

  // scheduler shadow state
  bit          task_loaded[16];
  bit          task_done[16];
  logic [15:0] task_arrival[16];
  logic [15:0] task_burst[16];
  logic [15:0] task_left[16];
  logic [7:0]  task_prio[16];
  logic [15:0] sched_now = '0;

  int bad_count = 0;
  int results_seen = 0;

  function automatic int draw_gap(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
    end
    if (r < 30) return 0;
    if (r < 70) return $urandom_range(1, 4);
    if (r < 92) return $urandom_range(5, 15);
    return $urandom_range(30, 80);
  endfunction

  task automatic schedule_item(input sched_item_t it);
    int            pick;
    logic [16:0]   tat;
    sched_result_t r;
    if (it.kind == KIND_LOAD) begin
      task_loaded[it.slot]  = 1'b1;
      task_done[it.slot]    = 1'b0;
      task_arrival[it.slot] = it.arrival;
      task_burst[it.slot]   = it.burst;
      task_left[it.slot]    = it.burst;
      task_prio[it.slot]    = it.prio;
      return;
    end
    pick = -1;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      if (task_loaded[k] && !task_done[k] && task_arrival[k] <= sched_now) begin
        if (pick < 0 || task_prio[k] < task_prio[pick]) pick = k;
      end
    end
    if (pick >= 0) begin
      r.slot = pick[3:0];
      // a zero burst completes without wrapping
      if (task_left[pick] != 0) task_left[pick]--;
      if (task_left[pick] == 0) begin
        task_done[pick] = 1'b1;
        tat = {1'b0, sched_now} + 17'd1 - {1'b0, task_arrival[pick]};
        if (tat > {1'b0, TIME_MAX}) tat = {1'b0, TIME_MAX};
        r.finished = 1'b1;
        r.turnaround = tat[15:0];
        r.waiting = (tat[15:0] >= task_burst[pick]) ? tat[15:0] - task_burst[pick] : 16'd0;
      end
    end else begin
      r.idle = 1'b1;
    end
    r.all_done = 1'b1;
    for (int k = 0; k < 16; k++) begin
      if (task_loaded[k] && !task_done[k]) r.all_done = 1'b0;
    end
    sched_expect.push_back(r);
    if (sched_now != TIME_MAX) sched_now++;
  endtask

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      bad_count++;
      if (bad_count <= 10)
        $display("mismatch in %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // driver
  sched_item_t next_item;
  sched_item_t cur_item;
  bit          have_next = 1'b0;
  int          gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) schedule_item(cur_item);
      if (!(in_tvalid && !in_tready)) begin
        if (!have_next && pending_items.size() > 0 &&
            (!pending_items[0].wait_drain || sched_expect.size() == 0)) begin
          next_item = pending_items.pop_front();
          have_next = 1'b1;
          gap_left = next_item.gap;
        end
        if (have_next && gap_left == 0) begin
          cur_item = next_item;
          have_next = 1'b0;
          in_tvalid <= 1'b1;
          in_tuser <= next_item.kind;
          in_tdata <= {4'b0, next_item.prio, next_item.burst, next_item.arrival,
                       next_item.slot};
        end else begin
          if (have_next) gap_left--;
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off so the block backs up
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int recv_mode = 1;
  int recv_count = 0;

  always @(posedge clk) begin
    logic ready_next;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        recv_count++;
        if (recv_count % 50 == 0) recv_mode = $urandom_range(0, 2);
        stall_left = draw_gap(recv_mode);
      end else if (out_tready && !out_tvalid && $urandom_range(0, 19) == 0) begin
        stall_left = draw_gap(recv_mode);
      end
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_tready <= ready_next;
    end
  end

  // monitor
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[38:0];
      results_seen++;
      if (sched_expect.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) $display("unexpected result, got %h", got);
      end else begin
        want = sched_expect.pop_front();
        check_field("idle", 16'(want.idle), 16'(got.idle));
        check_field("running_slot", 16'(want.slot), 16'(got.slot));
        check_field("finished", 16'(want.finished), 16'(got.finished));
        check_field("turnaround_time", want.turnaround, got.turnaround);
        check_field("waiting_time", want.waiting, got.waiting);
        check_field("all_done", 16'(want.all_done), 16'(got.all_done));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus
  logic [15:0] plan_time = '0;
  int          items_made = 0;
  bit          drain_next = 1'b0;

  task automatic push_load(input int slot, input int arrival, input int burst, input int prio,
                           input int gap);
    sched_item_t it;
    it.kind = KIND_LOAD;
    it.slot = slot[3:0];
    it.arrival = arrival[15:0];
    it.burst = burst[15:0];
    it.prio = prio[7:0];
    it.gap = gap;
    it.wait_drain = drain_next;
    drain_next = 1'b0;
    pending_items.push_back(it);
    items_made++;
  endtask

  task automatic push_tick(input int gap);
    sched_item_t it;
    it.kind = KIND_TICK;
    it.slot = 4'($urandom);
    it.arrival = 16'($urandom);
    it.burst = 16'($urandom);
    it.prio = 8'($urandom);
    it.gap = gap;
    it.wait_drain = drain_next;
    drain_next = 1'b0;
    pending_items.push_back(it);
    items_made++;
    if (plan_time != TIME_MAX) plan_time++;
  endtask

  function automatic int pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 3);
    if (r < 50) return 255;
    return $urandom_range(0, 255);
  endfunction

  initial begin
    int sender_mode;
    int mode_left;
    int choice;
    int work;
    int arr;
    int burst;
    int next_drain;

    // directed: empty table, zero burst, ties, far arrival, preemption, reloads
    push_tick(0);
    push_load(15, 0, 0, 255, 1);
    push_load(0, 0, 2, 255, 0);
    push_tick(0);
    push_tick(2);
    push_tick(0);
    push_load(3, 65535, 65535, 0, 0);
    push_load(4, 6, 3, 10, 0);
    push_tick(0);
    push_load(5, 0, 5, 0, 3);
    push_tick(0);
    push_tick(0);
    // reload while it is being served
    push_load(5, 0, 1, 20, 0);
    push_tick(0);
    push_tick(1);
    push_tick(0);
    push_tick(0);
    // reload of a completed slot
    push_load(0, 1, 1, 0, 0);
    push_tick(0);
    push_load(3, 0, 1, 200, 0);
    push_tick(0);
    push_tick(0);
    push_tick(5);

    sender_mode = 1;
    mode_left = 0;
    next_drain = 450;
    while (items_made < RANDOM_ITEMS) begin
      if (mode_left <= 0) begin
        sender_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 40);
      end
      mode_left--;
      if (items_made >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 450;
      end
      choice = $urandom_range(0, 99);
      if (choice < 75) begin
        // a batch of tasks near the current time, then ticks for their total burst and up to four more
        work = 0;
        repeat ($urandom_range(1, 5)) begin
          arr = int'(plan_time) + $urandom_range(0, 6);
          if (arr > 65535) arr = 65535;
          burst = $urandom_range(1, 6);
          push_load($urandom_range(0, 15), arr, burst, pick_prio(), draw_gap(sender_mode));
          work += burst;
        end
        repeat (work + $urandom_range(0, 4)) push_tick(draw_gap(sender_mode));
      end else if (choice < 88) begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 65535);
        arr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, int'(plan_time)) : $urandom;
        push_load($urandom_range(0, 15), arr, burst, $urandom_range(0, 255),
                  draw_gap(sender_mode));
      end else begin
        push_tick(draw_gap(sender_mode));
      end
    end

    // late in the run: short task, far arrival, zero burst
    drain_next = 1'b1;
    push_load(1, 0, 3, 0, 1);
    push_load(2, 65535, 4, 1, 0);
    push_load(3, 100, 0, 2, 0);
    repeat (10) push_tick($urandom_range(0, 3));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || have_next || in_tvalid) @(posedge clk);
    while (sched_expect.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (bad_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
